// ===== hdl/gbc_pkg.sv =====
// Shared widths, types and codes for the gyro bias calibration block.
package gbc_pkg;

    localparam int LANES      = 3;
    localparam int RAW_W      = 16;
    localparam int DELTA_W    = RAW_W + 1;
    localparam int SUM_W      = 24;
    localparam int CNT_W      = 8;
    localparam int SCALE_W    = 24;
    localparam int SCALE_FRAC = 24;
    localparam int RATE_FRAC  = 16;
    localparam int RATE_SHIFT = SCALE_FRAC - RATE_FRAC;
    localparam int RATE_W     = 33;
    localparam int PROD_W     = DELTA_W + SCALE_W + 1;
    localparam int STATUS_W   = 3;
    localparam int OK_W       = LANES;
    localparam int IN_DATA_W  = LANES * RAW_W;
    localparam int OUT_BITS   = LANES * (DELTA_W + RATE_W + RAW_W);
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic signed [RAW_W-1:0]   raw_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [RATE_W-1:0]  rate_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [SCALE_W-1:0]        scale_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_CAL    = 3'd0,
        STATUS_DONE   = 3'd1,
        STATUS_FAIL   = 3'd2,
        STATUS_DATA   = 3'd3,
        STATUS_RDFAIL = 3'd4
    } status_t;

    // Per-step commands from the sequencer to every lane.
    typedef struct packed {
        logic acc;
        logic acc_clear;
        logic clear;
        logic div_start;
        logic bias_load;
        logic load_delta;
        logic mul;
    } lane_ctrl_t;

endpackage

// ===== hdl/gyro_bias_calibrate_correct_top.sv =====
// Top level of the gyro zero-rate bias calibration and correction block.
//
// After reset the block drops discard_count samples, then averages the next
// sample_count samples per axis (only readings whose ok flag is set count)
// to form three biases, truncating toward zero. Every such sample returns a
// status-only transaction (calibrating); the last one returns "done" or, if
// an axis saw no good reading, "failed" and calibration restarts. Once
// calibrated, each sample with all three reads good returns raw minus bias
// and the rate delta * rate_scale / 2^8 (floor, signed Q16 rad/s); any bad
// read returns "read failed". The three axes run in parallel lanes; a merge
// stage packs their results into an output register, so a new sample is
// taken while the previous transaction still waits downstream. Discard,
// ordinary calibration and read-failed samples go from STEP to EMIT;
// corrected samples pass MUL on the way (one registered 17x25 multiply
// per lane), one that closes a calibration passes CHECK, and a good one
// then waits in DIV on the 24-step one-bit-per-cycle divider in each lane.
// Writes to the count registers apply from the next sample but
// no longer matter once calibrated; a rate_scale write applies to the next
// corrected sample. Write registers only while the block is idle.
module gyro_bias_calibrate_correct_top
    import gbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    // sample input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // raw_x, raw_y, raw_z
    input  logic [OK_W-1:0]       s_axis_tuser,  // x_ok, y_ok, z_ok
    // result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // delta_x, delta_y, delta_z, rate_x, rate_y, rate_z,
    // bias_x_out, bias_y_out, bias_z_out, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [STATUS_W-1:0]   m_axis_tuser   // status
);

    localparam logic [CFG_IDX_W-1:0] REG_DISCARD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_CHECK,
        S_DIV,
        S_MUL,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_DISCARD,
        PH_SAMPLE,
        PH_READY
    } phase_t;

    // configuration
    cnt_t    discard_reg;
    cnt_t    samples_reg;
    scale_t  scale_reg;

    // sequencer
    state_t  state_reg, state_next;
    phase_t  phase_reg, phase_next;
    cnt_t    counter_reg, counter_next;
    status_t status_reg, status_next;
    lane_ctrl_t ctrl;

    // latched sample
    raw_t        raw_reg [LANES];
    logic [OK_W-1:0] ok_reg;

    // lane results
    logic [LANES-1:0] count_zero;
    logic [LANES-1:0] div_done;
    delta_t      delta [LANES];
    rate_t       rate [LANES];
    raw_t        bias [LANES];

    logic        out_free;
    logic        out_load;
    logic        accept;
    cnt_t        target;
    cnt_t        cnt_inc;
    cnt_t        cnt_acc;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_EMIT) && out_free;

    // A zero sample count behaves as one.
    assign target  = (samples_reg == '0) ? CNT_W'(1) : samples_reg;
    assign cnt_inc = counter_reg + 1'b1;
    assign cnt_acc = (phase_reg == PH_DISCARD) ? CNT_W'(1) : cnt_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_reg <= CNT_W'(16);
            samples_reg <= CNT_W'(48);
            scale_reg   <= SCALE_W'(17851);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DISCARD: discard_reg <= wr_data[CNT_W-1:0];
                REG_SAMPLES: samples_reg <= wr_data[CNT_W-1:0];
                REG_SCALE:   scale_reg   <= wr_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < LANES; i++)
                raw_reg[i] <= s_axis_tdata[i*RAW_W +: RAW_W];
            ok_reg <= s_axis_tuser;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        counter_next = counter_reg;
        status_next  = status_reg;
        ctrl         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (phase_reg == PH_READY)
                begin
                    if (&ok_reg)
                    begin
                        ctrl.load_delta = 1'b1;
                        state_next      = S_MUL;
                    end
                    else
                    begin
                        status_next = STATUS_RDFAIL;
                        state_next  = S_EMIT;
                    end
                end
                else if (phase_reg == PH_DISCARD && counter_reg < discard_reg)
                begin
                    counter_next = cnt_inc;
                    status_next  = STATUS_CAL;
                    state_next   = S_EMIT;
                end
                else
                begin
                    // the sample that ends discarding is already sampled
                    ctrl.acc       = 1'b1;
                    ctrl.acc_clear = (phase_reg == PH_DISCARD);
                    counter_next   = cnt_acc;
                    phase_next     = PH_SAMPLE;
                    if (cnt_acc >= target)
                        state_next = S_CHECK;
                    else
                    begin
                        status_next = STATUS_CAL;
                        state_next  = S_EMIT;
                    end
                end
            end
            S_CHECK:
            begin
                if (|count_zero)
                begin
                    ctrl.clear   = 1'b1;
                    counter_next = '0;
                    phase_next   = PH_DISCARD;
                    status_next  = STATUS_FAIL;
                    state_next   = S_EMIT;
                end
                else
                begin
                    ctrl.div_start = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (&div_done)
                begin
                    ctrl.bias_load = 1'b1;
                    ctrl.clear     = 1'b1;
                    counter_next   = '0;
                    phase_next     = PH_READY;
                    status_next    = STATUS_DONE;
                    state_next     = S_EMIT;
                end
            end
            S_MUL:
            begin
                ctrl.mul    = 1'b1;
                status_next = STATUS_DATA;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_DISCARD;
            counter_reg <= '0;
            status_reg  <= STATUS_CAL;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            counter_reg <= counter_next;
            status_reg  <= status_next;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        gbc_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .raw        (raw_reg[g]),
            .ok         (ok_reg[g]),
            .scale      (scale_reg),
            .count_zero (count_zero[g]),
            .div_done   (div_done[g]),
            .delta      (delta[g]),
            .rate       (rate[g]),
            .bias       (bias[g])
        );
    end

    gbc_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .status        (status_reg),
        .delta         (delta),
        .rate          (rate),
        .bias          (bias),
        .free          (out_free),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== hdl/gbc_div.sv =====
// Restoring divider: signed sum over unsigned count, one quotient bit per cycle.
module gbc_div
    import gbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  sum_t  dividend,
    input  cnt_t  divisor,
    output raw_t  quotient,
    output logic  done
);

    localparam int STEP_W = $clog2(SUM_W);

    logic [SUM_W-1:0]  work_reg, work_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    cnt_t              div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [CNT_W:0]    trial;
    logic              qbit;
    logic [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]  q_signed;

    assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign trial = {rem_reg, work_reg[SUM_W-1]};
    assign qbit  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        rem_next  = qbit ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
        work_next = {work_reg[SUM_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= mag;
            rem_reg  <= '0;
            div_reg  <= divisor;
            neg_reg  <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    // Quotient magnitude never exceeds the raw range, so the low bits suffice.
    assign q_signed = neg_reg ? (~work_reg + 1'b1) : work_reg;
    assign quotient = q_signed[RAW_W-1:0];
    assign done     = done_reg;

endmodule

// ===== hdl/gbc_lane.sv =====
// One axis lane: accumulator, bias divider, bias store and rate scaler.
module gbc_lane
    import gbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctrl,
    input  raw_t       raw,
    input  logic       ok,
    input  scale_t     scale,
    output logic       count_zero,
    output logic       div_done,
    output delta_t     delta,
    output rate_t      rate,
    output raw_t       bias
);

    sum_t                     sum_reg, sum_next;
    cnt_t                     count_reg, count_next;
    raw_t                     bias_reg;
    delta_t                   delta_reg;
    logic signed [PROD_W-1:0] prod_reg;
    raw_t                     quotient;

    gbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        sum_next   = ctrl.acc_clear ? '0 : sum_reg;
        count_next = ctrl.acc_clear ? '0 : count_reg;
        if (ok)
        begin
            sum_next   = sum_next + {{(SUM_W-RAW_W){raw[RAW_W-1]}}, raw};
            count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            bias_reg  <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else if (ctrl.acc)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
            if (ctrl.bias_load)
                bias_reg <= quotient;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_delta)
            delta_reg <= $signed({raw[RAW_W-1], raw}) - $signed({bias_reg[RAW_W-1], bias_reg});
        if (ctrl.mul)
            prod_reg <= PROD_W'(delta_reg * $signed({1'b0, scale}));
    end

    assign count_zero = (count_reg == '0);
    assign delta      = delta_reg;
    // Arithmetic shift right gives the floor of the scaled product.
    assign rate       = prod_reg[RATE_SHIFT +: RATE_W];
    assign bias       = bias_reg;

endmodule

// ===== hdl/gbc_merge.sv =====
// Output stage: merges the lane results and status into one held transaction.
module gbc_merge
    import gbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  status_t               status,
    input  delta_t                delta [LANES],
    input  rate_t                 rate [LANES],
    input  raw_t                  bias [LANES],
    output logic                  free,
    input  logic                  m_axis_tready,
    output logic                  m_axis_tvalid,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [STATUS_W-1:0]   m_axis_tuser
);

    localparam int RATE_BASE = LANES * DELTA_W;
    localparam int BIAS_BASE = RATE_BASE + LANES * RATE_W;

    logic                  tvalid_reg;
    logic [OUT_DATA_W-1:0] tdata_reg, tdata_next;
    logic [STATUS_W-1:0]   tuser_reg;
    logic                  is_data;

    assign is_data = (status == STATUS_DATA);

    always_comb
    begin
        tdata_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            tdata_next[i*DELTA_W +: DELTA_W]            = is_data ? delta[i] : '0;
            tdata_next[RATE_BASE + i*RATE_W +: RATE_W]  = is_data ? rate[i] : '0;
            tdata_next[BIAS_BASE + i*RAW_W +: RAW_W]    = bias[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tvalid_reg <= 1'b0;
        else if (load)
            tvalid_reg <= 1'b1;
        else if (m_axis_tready)
            tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= status;
        end
    end

    assign free          = !tvalid_reg || m_axis_tready;
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

// ===== tb/gbc_tb_pkg.sv =====
// Register indexes and reset values of the gyro bias calibration configuration port.
`timescale 1ns / 1ps

package gbc_tb_pkg;

    import gbc_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISCARD    = 2'd0,
        REG_SAMPLE     = 2'd1,
        REG_RATE_SCALE = 2'd2
    } cfg_reg_t;

    localparam int DISCARD_RESET = 16;
    localparam int SAMPLE_RESET  = 48;
    localparam int SCALE_RESET   = 17851;

endpackage

// ===== tb/gbc_checker.sv =====
// Scoreboard for the gyro bias calibration block: predicts each result and compares it.
`timescale 1ns / 1ps

module gbc_checker
    import gbc_pkg::*;
    import gbc_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [OK_W-1:0]       in_ok,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [OUT_DATA_W-1:0] out_data,
    input  logic [STATUS_W-1:0]   out_status,
    output int                    errors,
    output int                    pending
);

    localparam int RATE_LSB = LANES * DELTA_W;
    localparam int BIAS_LSB = RATE_LSB + LANES * RATE_W;

    typedef enum logic [1:0] {
        CAL_SKIP,
        CAL_AVERAGE,
        CAL_LOCKED
    } cal_phase_t;

    typedef struct {
        status_t status;
        delta_t  delta [LANES];
        rate_t   rate  [LANES];
        raw_t    bias  [LANES];
    } gyro_result_t;

    // register copies
    cnt_t       skip_target;
    cnt_t       avg_target;
    scale_t     scale;

    // calibration state
    cal_phase_t cal_phase;
    cnt_t       item_cnt;
    cnt_t       good_cnt  [LANES];
    sum_t       lane_sum  [LANES];
    raw_t       lane_bias [LANES];

    gyro_result_t gyro_results_q [$];
    gyro_result_t want;
    int           results_seen;

    function automatic void clear_accum();
        int a;
        item_cnt = '0;
        for (a = 0; a < LANES; a++)
        begin
            good_cnt[a] = '0;
            lane_sum[a] = '0;
        end
    endfunction

    function automatic gyro_result_t calibrate_and_correct(input logic [IN_DATA_W-1:0] data,
                                                           input logic [OK_W-1:0] ok);
        gyro_result_t r;
        raw_t         raw [LANES];
        cnt_t         goal;
        longint       d;
        longint       p;
        int           a;
        r.status = STATUS_CAL;
        for (a = 0; a < LANES; a++)
        begin
            raw[a]     = data[a*RAW_W +: RAW_W];
            r.delta[a] = '0;
            r.rate[a]  = '0;
        end

        if (cal_phase == CAL_SKIP)
        begin
            if (item_cnt < skip_target)
                item_cnt++;
            else
            begin
                // this item is the first one averaged
                cal_phase = CAL_AVERAGE;
                clear_accum();
            end
        end

        if (cal_phase == CAL_AVERAGE)
        begin
            goal = (avg_target == '0) ? cnt_t'(1) : avg_target;
            for (a = 0; a < LANES; a++)
            begin
                if (ok[a])
                begin
                    lane_sum[a] = lane_sum[a] + raw[a];
                    good_cnt[a]++;
                end
            end
            item_cnt++;
            if (item_cnt >= goal)
            begin
                if (good_cnt[0] == '0 || good_cnt[1] == '0 || good_cnt[2] == '0)
                begin
                    r.status  = STATUS_FAIL;
                    cal_phase = CAL_SKIP;
                end
                else
                begin
                    // signed divide truncates toward zero
                    for (a = 0; a < LANES; a++)
                        lane_bias[a] = raw_t'(longint'(lane_sum[a]) / longint'(good_cnt[a]));
                    r.status  = STATUS_DONE;
                    cal_phase = CAL_LOCKED;
                end
                clear_accum();
            end
        end
        else if (cal_phase == CAL_LOCKED)
        begin
            if (&ok)
            begin
                r.status = STATUS_DATA;
                for (a = 0; a < LANES; a++)
                begin
                    d          = longint'(raw[a]) - longint'(lane_bias[a]);
                    p          = d * longint'(scale);
                    r.delta[a] = delta_t'(d);
                    r.rate[a]  = rate_t'(p >>> RATE_SHIFT);  // floor
                end
            end
            else
                r.status = STATUS_RDFAIL;
        end

        for (a = 0; a < LANES; a++)
            r.bias[a] = lane_bias[a];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int lane,
                                   input logic [63:0] got, input logic [63:0] exp_val);
        errors++;
        $display("[%0t] result %0d: %s lane %0d: got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, lane, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int a;
        if (!rst_n)
        begin
            skip_target  = cnt_t'(DISCARD_RESET);
            avg_target   = cnt_t'(SAMPLE_RESET);
            scale        = scale_t'(SCALE_RESET);
            cal_phase    = CAL_SKIP;
            clear_accum();
            for (a = 0; a < LANES; a++)
                lane_bias[a] = '0;
            gyro_results_q.delete();
            results_seen = 0;
            errors       = 0;
            pending      = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (gyro_results_q.size() == 0)
                    report_mismatch("unexpected result, status", 0, out_status, 0);
                else
                begin
                    want = gyro_results_q.pop_front();
                    if (out_status !== want.status)
                        report_mismatch("status", 0, out_status, want.status);
                    for (a = 0; a < LANES; a++)
                    begin
                        if (out_data[a*DELTA_W +: DELTA_W] !== want.delta[a])
                            report_mismatch("delta", a, out_data[a*DELTA_W +: DELTA_W],
                                            $unsigned(want.delta[a]));
                        if (out_data[RATE_LSB + a*RATE_W +: RATE_W] !== want.rate[a])
                            report_mismatch("rate", a, out_data[RATE_LSB + a*RATE_W +: RATE_W],
                                            $unsigned(want.rate[a]));
                        if (out_data[BIAS_LSB + a*RAW_W +: RAW_W] !== want.bias[a])
                            report_mismatch("bias", a, out_data[BIAS_LSB + a*RAW_W +: RAW_W],
                                            $unsigned(want.bias[a]));
                    end
                end
                results_seen++;
            end

            if (wr_en)
            begin
                case (wr_index)
                    REG_DISCARD:    skip_target = wr_data[CNT_W-1:0];
                    REG_SAMPLE:     avg_target  = wr_data[CNT_W-1:0];
                    REG_RATE_SCALE: scale       = wr_data[SCALE_W-1:0];
                    default:        ;
                endcase
            end

            if (in_valid && in_ready)
                gyro_results_q.push_back(calibrate_and_correct(in_data, in_ok));

            pending = gyro_results_q.size();
        end
    end

endmodule

// ===== tb/gyro_bias_calibrate_correct_top_test.sv =====
// Testbench top for the gyro bias calibration block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module gyro_bias_calibrate_correct_top_test;

    import gbc_pkg::*;
    import gbc_tb_pkg::*;

    // Settle time, long enough for a closing calibration's divide to finish.
    localparam int SETTLE_CYCLES = 40;
    // Slowest legal run is roughly 1100 transactions, each with a long sender
    // gap, a divide and a long receiver stall; this is several times that.
    localparam int CYCLE_LIMIT   = 600000;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // raw_x, raw_y, raw_z
    logic [OK_W-1:0]       s_axis_tuser;   // x_ok, y_ok, z_ok
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // delta_x/y/z, rate_x/y/z, bias_x/y/z, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;   // status

    int errors;
    int pending;
    int cycle_count;
    // Counters for gap-free stretches on each side
    int send_calm;
    int recv_calm;

    gyro_bias_calibrate_correct_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gbc_checker gbc_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_ok      (s_axis_tuser),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_status (m_axis_tuser),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length in cycles: mostly none or short, now and then long, and
    // occasionally a stretch of back-to-back transactions.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Raw count with a bias towards the corners of the 16-bit range
    function automatic raw_t pick_raw();
        case ($urandom_range(0, 15))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return '1;
            default: return raw_t'($urandom);
        endcase
    endfunction

    // Receiver: random back-pressure, changed on the falling edge only
    initial
    begin
        int hold;
        hold          = 0;
        recv_calm     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = pick_gap(recv_calm);
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("gyro_bias_calibrate_correct_top regression: fail");
        $finish;
    end

    // Config write; waits with wr_en low before returning so that
    // back-to-back writes never touch wr_en twice in one step.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(negedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one sample; returns on the falling edge after the transaction.
    // tvalid is left high so the next call can follow without a bubble.
    task automatic send_sample(input raw_t x, input raw_t y, input raw_t z,
                               input logic [OK_W-1:0] ok);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tuser  <= ok;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Sender holds off until every outstanding result has been taken and the
    // block has had time to finish any internal work.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // A calibration doomed to fail: one axis never reports a good read, so
    // the block must return "failed" on the last sample and start over.
    task automatic failing_calibration(input int skip, input int average);
        int bad;
        int n;
        bad = $urandom_range(0, LANES - 1);
        settle();
        write_reg(REG_DISCARD, skip);
        write_reg(REG_SAMPLE, average);
        n = skip + ((average == 0) ? 1 : average);
        repeat (n)
            send_sample(pick_raw(), pick_raw(), pick_raw(), 3'($urandom) & ~(3'b001 << bad));
    endtask

    // Corrected-sample traffic once calibrated: mostly clean reads, some failures
    task automatic correction_run(input int n);
        repeat (n)
            send_sample(pick_raw(), pick_raw(), pick_raw(),
                        ($urandom_range(0, 99) < 85) ? 3'b111 : 3'($urandom));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        wr_en         = 1'b0;
        wr_index      = REG_DISCARD;
        wr_data       = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        send_calm     = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // No discard, zero sample count (acts as one): every sample closes a
        // calibration at once, and each of these lacks a good read somewhere.
        write_reg(REG_DISCARD, 0);
        write_reg(REG_SAMPLE, 0);
        send_sample(16'sd100, -16'sd100, 16'sd7, 3'b000);
        send_sample(16'sh7FFF, 16'sh8000, 16'sd0, 3'b001);
        send_sample(16'sh8000, 16'sh7FFF, -16'sd1, 3'b110);

        // Short failing run, then the extremes of both counts
        failing_calibration(3, 4);
        failing_calibration(255, 255);

        // A few random sizes, including a zero sample count now and then
        repeat (3)
            failing_calibration($urandom_range(0, 12), $urandom_range(0, 25));
        failing_calibration(DISCARD_RESET, SAMPLE_RESET);

        // Calibration that succeeds: one discarded sample, three averaged.
        // x and y keep the range corners as bias; z has a mixed count and a
        // negative sum that must truncate towards zero.
        settle();
        write_reg(REG_DISCARD, 1);
        write_reg(REG_SAMPLE, 3);
        send_sample(16'sd1234, -16'sd4321, 16'sd99, 3'b111);
        send_sample(16'sh7FFF, 16'sh8000, -16'sd32767, 3'b111);
        send_sample(16'sh7FFF, 16'sh8000, 16'sd0, 3'b111);
        send_sample(-16'sd5, 16'sd7, 16'sd12345, 3'b100);

        // Largest scale with the widest deltas, then each axis failing in turn
        settle();
        write_reg(REG_RATE_SCALE, 24'hFFFFFF);
        send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 3'b111);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 3'b111);
        send_sample(16'sd0, 16'sd0, 16'sd0, 3'b111);
        send_sample(-16'sd1, 16'sd1, -16'sd1, 3'b111);
        send_sample(16'sd10, 16'sd20, 16'sd30, 3'b110);
        send_sample(16'sd10, 16'sd20, 16'sd30, 3'b101);
        send_sample(16'sd10, 16'sd20, 16'sd30, 3'b011);
        send_sample(16'sd10, 16'sd20, 16'sd30, 3'b000);
        correction_run(80);

        // Scale sweep: zero, one, power-on value and random. The count
        // registers are rewritten too; once calibrated they must not matter.
        settle();
        write_reg(REG_RATE_SCALE, 0);
        correction_run(80);
        settle();
        write_reg(REG_DISCARD, $urandom_range(0, 255));
        write_reg(REG_SAMPLE, $urandom_range(0, 255));
        write_reg(REG_RATE_SCALE, 1);
        correction_run(80);
        settle();
        write_reg(REG_RATE_SCALE, SCALE_RESET);
        correction_run(80);
        repeat (2)
        begin
            settle();
            write_reg(REG_RATE_SCALE, $urandom_range(0, 24'hFFFFFF));
            correction_run(80);
        end

        // Drain everything, then give the verdict
        settle();
        if (errors == 0)
            $display("gyro_bias_calibrate_correct_top regression: pass");
        else
            $display("gyro_bias_calibrate_correct_top regression: fail");
        $finish;
    end

endmodule
